FILE: rtl/core/kta_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// kta_pkg
// Shared widths, codes, constants and angle tables for the Kepler anomaly
// solver.
// ---------------------------------------------------------------------------
package kta_pkg;

    localparam int NEWTON_STEP_LIMIT_DEF = 10;
    localparam int ANGLE_FRAC_BITS_DEF   = 29;

    localparam int TIME_W    = 48;
    localparam int PERIOD_W  = 47;
    localparam int ECC_W     = 32;
    localparam int ANOM_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 48;

    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 48;
    localparam int DIV_CNT_W = 7;
    localparam int MUL_W     = 33;
    localparam int MUL_P_W   = 2 * MUL_W;

    localparam logic [63:0] PI_Q61          = 64'h6487ED5110B4611A;
    localparam logic [63:0] TWO_PI_Q61      = 64'hC90FDAA22168C234;
    localparam logic [63:0] HALF_PI_Q61     = 64'h3243F6A8885A308D;
    localparam logic [63:0] CORDIC_GAIN_Q30 = 64'd652032874;
    localparam logic [32:0] E_ONE_Q31       = 33'h080000000;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK           = 2'd0,
        STATUS_PERIOD_ZERO  = 2'd1,
        STATUS_NOT_ELLIPTIC = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ECCENTRICITY   = 2'd0,
        CFG_ORBIT_PERIOD   = 2'd1,
        CFG_PERIAPSIS_TIME = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic start;
        logic vec;
    } cordic_ctl_t;

    function automatic logic [63:0] from_q61(input logic [63:0] c, input int f);
        logic [64:0] t;
        t = {1'b0, c} + (65'd1 << (60 - f));
        return 64'(t >> (61 - f));
    endfunction

    function automatic logic [63:0] from_q30(input logic [63:0] c, input int f);
        logic [64:0] t;
        t = {1'b0, c} + (65'd1 << (29 - f));
        return 64'(t >> (30 - f));
    endfunction

    function automatic logic [63:0] atan_step(input logic [5:0] i, input int f);
        logic [63:0] tab;
        case (i)
            6'd0:    tab = 64'd843314857;
            6'd1:    tab = 64'd497837829;
            6'd2:    tab = 64'd263043837;
            6'd3:    tab = 64'd133525159;
            6'd4:    tab = 64'd67021687;
            6'd5:    tab = 64'd33543516;
            6'd6:    tab = 64'd16775851;
            6'd7:    tab = 64'd8388437;
            6'd8:    tab = 64'd4194283;
            6'd9:    tab = 64'd2097149;
            default: tab = 64'd0;
        endcase
        if (i < 6'd10) begin
            return from_q30(tab, f);
        end
        return 64'd1 << (f - int'(i));
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/kta_mul.sv
`default_nettype none
// ---------------------------------------------------------------------------
// kta_mul
// Shared signed multiplier, product registered.
// ---------------------------------------------------------------------------
module kta_mul (
    input  wire logic                                   aclk,
    input  wire logic signed [kta_pkg::MUL_W-1:0]       a,
    input  wire logic signed [kta_pkg::MUL_W-1:0]       b,
    output logic signed      [kta_pkg::MUL_P_W-1:0]     prod
);

    logic signed [kta_pkg::MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

FILE: rtl/core/kta_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// kta_div
// Restoring shift-subtract divider, one quotient bit per cycle. The step
// count and a preloaded remainder let it serve both integer and fraction
// division.
// ---------------------------------------------------------------------------
module kta_div (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire logic [kta_pkg::DIV_NUM_W-1:0]      num,
    input  wire logic [kta_pkg::DIV_DEN_W-1:0]      rem_init,
    input  wire logic [kta_pkg::DIV_DEN_W-1:0]      den,
    input  wire logic [kta_pkg::DIV_CNT_W-1:0]      steps,
    output logic                                    done,
    output logic      [kta_pkg::DIV_NUM_W-1:0]      quot,
    output logic      [kta_pkg::DIV_DEN_W-1:0]      rem
);

    localparam int NW = kta_pkg::DIV_NUM_W;
    localparam int DW = kta_pkg::DIV_DEN_W;

    logic                               busy_reg;
    logic                               done_reg;
    logic [kta_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic [NW-1:0]                      num_reg;
    logic [NW-1:0]                      quo_reg;
    logic [DW-1:0]                      rem_reg;
    logic [DW-1:0]                      den_reg;
    logic [DW:0]                        trial;
    logic [DW:0]                        diff;
    logic                               ge;
    logic [DW-1:0]                      rem_next;

    always_comb begin
        trial    = {rem_reg, num_reg[NW-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == kta_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            rem_reg <= rem_init;
            den_reg <= den;
            quo_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NW-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

FILE: rtl/core/kta_sqrt.sv
`default_nettype none
// ---------------------------------------------------------------------------
// kta_sqrt
// Bitwise integer square root, floored, one result bit per cycle.
// ---------------------------------------------------------------------------
module kta_sqrt #(
    parameter  int ANGLE_FRAC_BITS = kta_pkg::ANGLE_FRAC_BITS_DEF,
    localparam int SW = 2 * ANGLE_FRAC_BITS + 2,
    localparam int RW = ANGLE_FRAC_BITS + 2
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire logic [SW-1:0]  val,
    output logic                done,
    output logic      [RW-1:0]  root
);

    logic           busy_reg;
    logic           done_reg;
    logic [SW-1:0]  v_reg;
    logic [SW-1:0]  res_reg;
    logic [SW-1:0]  bit_reg;
    logic [SW:0]    trial;
    logic           ge;

    always_comb begin
        trial = {1'b0, res_reg} + {1'b0, bit_reg};
        ge    = {1'b0, v_reg} >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg[0]) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= val;
            res_reg <= '0;
            bit_reg <= SW'(1) << (SW - 2);
        end else if (busy_reg) begin
            if (ge) begin
                v_reg   <= SW'({1'b0, v_reg} - trial);
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[RW-1:0];

endmodule
`default_nettype wire

FILE: rtl/core/kta_cordic.sv
`default_nettype none
// ---------------------------------------------------------------------------
// kta_cordic
// Shared CORDIC, one micro-rotation per cycle. Rotation mode returns
// cos/sin of an angle after quadrant folding; vectoring mode returns the
// arctangent of a vector.
// ---------------------------------------------------------------------------
module kta_cordic #(
    parameter  int ANGLE_FRAC_BITS = kta_pkg::ANGLE_FRAC_BITS_DEF,
    localparam int AW = ANGLE_FRAC_BITS + 8
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire kta_pkg::cordic_ctl_t       ctl,
    input  wire logic signed [AW-1:0]       a_in,
    input  wire logic signed [AW-1:0]       x_in,
    input  wire logic signed [AW-1:0]       y_in,
    output logic                            done,
    output logic signed      [AW-1:0]       x_out,
    output logic signed      [AW-1:0]       y_out,
    output logic signed      [AW-1:0]       z_out
);

    localparam int CW = $clog2(ANGLE_FRAC_BITS + 1);
    localparam logic signed [AW-1:0] PI_A =
        AW'(kta_pkg::from_q61(kta_pkg::PI_Q61, ANGLE_FRAC_BITS));
    localparam logic signed [AW-1:0] TWO_PI_A =
        AW'(kta_pkg::from_q61(kta_pkg::TWO_PI_Q61, ANGLE_FRAC_BITS));
    localparam logic signed [AW-1:0] HALF_A =
        AW'(kta_pkg::from_q61(kta_pkg::HALF_PI_Q61, ANGLE_FRAC_BITS));
    localparam logic signed [AW-1:0] GAIN_A =
        AW'(kta_pkg::from_q30(kta_pkg::CORDIC_GAIN_Q30, ANGLE_FRAC_BITS));

    logic                   busy_reg;
    logic                   done_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   vec_reg;
    logic                   flip_reg;
    logic signed [AW-1:0]   x_reg;
    logic signed [AW-1:0]   y_reg;
    logic signed [AW-1:0]   z_reg;

    logic signed [AW-1:0]   a_fold;
    logic                   flip;
    logic signed [AW-1:0]   dx;
    logic signed [AW-1:0]   dy;
    logic signed [AW-1:0]   step;
    logic                   up;

    always_comb begin
        a_fold = a_in;
        flip   = 1'b0;
        if (a_fold > PI_A) begin
            a_fold = a_fold - TWO_PI_A;
        end
        if (a_fold < -PI_A) begin
            a_fold = a_fold + TWO_PI_A;
        end
        if (a_fold > HALF_A) begin
            a_fold = a_fold - PI_A;
            flip   = 1'b1;
        end else if (a_fold < -HALF_A) begin
            a_fold = a_fold + PI_A;
            flip   = 1'b1;
        end
    end

    always_comb begin
        dx   = y_reg >>> cnt_reg;
        dy   = x_reg >>> cnt_reg;
        step = AW'(kta_pkg::atan_step(6'(cnt_reg), ANGLE_FRAC_BITS));
        up   = vec_reg ? y_reg[AW-1] : ~z_reg[AW-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(ANGLE_FRAC_BITS)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            vec_reg <= ctl.vec;
            if (ctl.vec) begin
                flip_reg <= 1'b0;
                z_reg    <= '0;
                x_reg    <= x_in[AW-1] ? -x_in : x_in;
                y_reg    <= x_in[AW-1] ? -y_in : y_in;
            end else begin
                flip_reg <= flip;
                z_reg    <= a_fold;
                x_reg    <= GAIN_A;
                y_reg    <= '0;
            end
        end else if (busy_reg) begin
            if (up) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - step;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + step;
            end
        end
    end

    assign done  = done_reg;
    assign x_out = flip_reg ? -x_reg : x_reg;
    assign y_out = flip_reg ? -y_reg : y_reg;
    assign z_out = z_reg;

endmodule
`default_nettype wire

FILE: rtl/core/kepler_true_anomaly_from_time.sv
`default_nettype none
// ---------------------------------------------------------------------------
// kepler_true_anomaly_from_time
// True anomaly of an elliptic orbit from a query time: mean anomaly by
// serial modulo and fraction division, Kepler's equation by Newton steps,
// then half-angle CORDIC, square roots and a vectoring arctangent.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake            | word
//  cfg      | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  s        | in        | s_valid/s_ready      | s_query_time
//  m        | out       | m_valid/m_ready      | m_true_anomaly, m_status
//
//  One word at a time, with 1..NEWTON_STEP_LIMIT+1 Newton steps per word,
//  each using the 64-step serial divider. A zero period or non-elliptic
//  eccentricity skips the solver and answers with an error status.
//  Synchronous active-low reset clears the sequencer and output valid.
//  s_ready is high only when idle; a result waits in the output register
//  while the next word is accepted. cfg_ready is always high.
// ---------------------------------------------------------------------------
module kepler_true_anomaly_from_time #(
    parameter int NEWTON_STEP_LIMIT = kta_pkg::NEWTON_STEP_LIMIT_DEF,
    parameter int ANGLE_FRAC_BITS   = kta_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [kta_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [kta_pkg::CFG_W-1:0]              cfg_data,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic signed [kta_pkg::TIME_W-1:0]      s_query_time,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [kta_pkg::ANOM_W-1:0]           m_true_anomaly,
    output logic        [kta_pkg::STATUS_W-1:0]         m_status
);

    localparam int F      = ANGLE_FRAC_BITS;
    localparam int AW     = F + 8;
    localparam int EW     = 2 * F + 8;
    localparam int SW     = 2 * F + 2;
    localparam int RW     = F + 2;
    localparam int KW     = $clog2(NEWTON_STEP_LIMIT + 1);
    localparam int SHIFT2 = 2 * F - 31;
    localparam int MW     = kta_pkg::MUL_W;
    localparam int PW     = kta_pkg::MUL_P_W;
    localparam int TW     = kta_pkg::TIME_W;
    localparam int PERW   = kta_pkg::PERIOD_W;

    localparam logic signed [AW-1:0] ONE_A = AW'(1) << F;
    localparam logic signed [AW:0] PI_W =
        (AW + 1)'(kta_pkg::from_q61(kta_pkg::PI_Q61, F));
    localparam logic [31:0] TWO_PI_F = 32'(kta_pkg::from_q61(kta_pkg::TWO_PI_Q61, F));

    typedef enum logic [23:0] {
        S_IDLE      = 24'h000001,
        S_MOD_GO    = 24'h000002,
        S_MOD_WAIT  = 24'h000004,
        S_FRAC_GO   = 24'h000008,
        S_FRAC_WAIT = 24'h000010,
        S_MMUL      = 24'h000020,
        S_MCAP      = 24'h000040,
        S_SC_GO     = 24'h000080,
        S_SC_WAIT   = 24'h000100,
        S_EMS       = 24'h000200,
        S_EMC       = 24'h000400,
        S_DIV_GO    = 24'h000800,
        S_DIV_WAIT  = 24'h001000,
        S_HALF_GO   = 24'h002000,
        S_HALF_WAIT = 24'h004000,
        S_SQM_GO    = 24'h008000,
        S_SQM_WAIT  = 24'h010000,
        S_SQP_GO    = 24'h020000,
        S_SQP_WAIT  = 24'h040000,
        S_XS        = 24'h080000,
        S_YS        = 24'h100000,
        S_VEC_GO    = 24'h200000,
        S_VEC_WAIT  = 24'h400000,
        S_OUT       = 24'h800000
    } state_t;

    state_t                         state_reg;
    logic [KW-1:0]                  k_reg;
    logic                           m_valid_reg;
    logic signed [31:0]             m_ta_reg;
    logic [1:0]                     m_st_reg;
    logic signed [31:0]             res_ta_reg;
    kta_pkg::status_t               res_st_reg;

    logic [kta_pkg::ECC_W-1:0]      ecc_reg;
    logic [PERW-1:0]                period_reg;
    logic signed [TW-1:0]           peri_reg;
    logic signed [TW-1:0]           t_reg;
    logic                           neg_reg;
    logic [PERW-1:0]                rem_reg;
    logic [31:0]                    q_reg;
    logic signed [AW-1:0]           m_reg;
    logic signed [AW-1:0]           e_reg;
    logic signed [AW-1:0]           f_reg;
    logic signed [AW-1:0]           s_reg;
    logic signed [AW-1:0]           c_reg;
    logic signed [AW-1:0]           xs_reg;
    logic [RW-1:0]                  sm_reg;
    logic [RW-1:0]                  sp_reg;

    logic signed [MW-1:0]           mul_a;
    logic signed [MW-1:0]           mul_b;
    logic signed [PW-1:0]           prod;

    logic                           div_start;
    logic [kta_pkg::DIV_NUM_W-1:0]  div_num;
    logic [kta_pkg::DIV_DEN_W-1:0]  div_rem_init;
    logic [kta_pkg::DIV_DEN_W-1:0]  div_den;
    logic [kta_pkg::DIV_CNT_W-1:0]  div_steps;
    logic                           div_done;
    logic [kta_pkg::DIV_NUM_W-1:0]  div_quot;
    logic [kta_pkg::DIV_DEN_W-1:0]  div_rem;

    kta_pkg::cordic_ctl_t           cor_ctl;
    logic signed [AW-1:0]           cor_a;
    logic signed [AW-1:0]           cor_y;
    logic                           cor_done;
    logic signed [AW-1:0]           cor_x_out;
    logic signed [AW-1:0]           cor_y_out;
    logic signed [AW-1:0]           cor_z_out;

    logic                           sq_start;
    logic [SW-1:0]                  sq_val;
    logic                           sq_done;
    logic [RW-1:0]                  sq_root;

    logic signed [TW:0]             dt;
    logic [TW:0]                    dt_mag;
    logic [PERW-1:0]                rem_fix;
    logic signed [AW-1:0]           d_raw;
    logic signed [AW-1:0]           d_val;
    logic [AW-1:0]                  f_mag;
    logic signed [EW-1:0]           qz;
    logic signed [EW-1:0]           e_wide;
    logic signed [EW-1:0]           e_hi;
    logic signed [EW-1:0]           e_lo;
    logic signed [AW-1:0]           e_clamp;
    logic signed [AW:0]             nu;
    logic signed [AW:0]             nu_clamp;
    logic [32:0]                    e_minus;
    logic [32:0]                    e_plus;

    // datapath helpers
    always_comb begin
        dt      = {t_reg[TW-1], t_reg} - {peri_reg[TW-1], peri_reg};
        dt_mag  = dt[TW] ? -dt : dt;
        rem_fix = (neg_reg && (div_rem[PERW-1:0] != '0))
                  ? period_reg - div_rem[PERW-1:0] : div_rem[PERW-1:0];
        d_raw   = ONE_A - AW'(prod >>> 31);
        d_val   = (d_raw < AW'(1)) ? AW'(1) : d_raw;
        f_mag   = f_reg[AW-1] ? -f_reg : f_reg;
        qz      = EW'(div_quot);
        e_wide  = EW'(e_reg) - (f_reg[AW-1] ? -qz : qz);
        e_hi    = EW'(m_reg) + EW'(ONE_A);
        e_lo    = EW'(m_reg) - EW'(ONE_A);
        if (e_wide > e_hi) begin
            e_clamp = AW'(e_hi);
        end else if (e_wide < e_lo) begin
            e_clamp = AW'(e_lo);
        end else begin
            e_clamp = AW'(e_wide);
        end
        nu = {cor_z_out, 1'b0};
        if (nu > PI_W) begin
            nu_clamp = PI_W;
        end else if (nu < -PI_W) begin
            nu_clamp = -PI_W;
        end else begin
            nu_clamp = nu;
        end
        e_minus = kta_pkg::E_ONE_Q31 - {1'b0, ecc_reg};
        e_plus  = kta_pkg::E_ONE_Q31 + {1'b0, ecc_reg};
    end

    // shared unit operand steering
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MMUL: begin
                mul_a = $signed(MW'(q_reg));
                mul_b = $signed(MW'(TWO_PI_F));
            end
            S_EMS: begin
                mul_a = $signed(MW'(ecc_reg));
                mul_b = MW'(s_reg);
            end
            S_EMC: begin
                mul_a = $signed(MW'(ecc_reg));
                mul_b = MW'(c_reg);
            end
            S_XS: begin
                mul_a = MW'(c_reg);
                mul_b = $signed(MW'(sm_reg));
            end
            S_YS: begin
                mul_a = MW'(s_reg);
                mul_b = $signed(MW'(sp_reg));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_start    = 1'b0;
        div_num      = '0;
        div_rem_init = '0;
        div_den      = kta_pkg::DIV_DEN_W'(period_reg);
        div_steps    = kta_pkg::DIV_CNT_W'(kta_pkg::DIV_NUM_W);
        case (state_reg)
            S_MOD_GO: begin
                div_start = 1'b1;
                div_num   = kta_pkg::DIV_NUM_W'(dt_mag);
            end
            S_FRAC_GO: begin
                div_start    = 1'b1;
                div_rem_init = kta_pkg::DIV_DEN_W'(rem_reg);
                div_steps    = kta_pkg::DIV_CNT_W'(32);
            end
            S_DIV_GO: begin
                div_start = 1'b1;
                div_num   = kta_pkg::DIV_NUM_W'({f_mag, {F{1'b0}}});
                div_den   = kta_pkg::DIV_DEN_W'(d_val);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        cor_ctl.start = (state_reg == S_SC_GO) || (state_reg == S_HALF_GO)
                        || (state_reg == S_VEC_GO);
        cor_ctl.vec   = (state_reg == S_VEC_GO);
        cor_a         = (state_reg == S_HALF_GO) ? (e_reg >>> 1) : e_reg;
        cor_y         = AW'(prod >>> F);
        sq_start      = (state_reg == S_SQM_GO) || (state_reg == S_SQP_GO);
        sq_val        = (state_reg == S_SQP_GO) ? (SW'(e_plus) << SHIFT2)
                                                : (SW'(e_minus) << SHIFT2);
    end

    kta_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    kta_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (div_num),
        .rem_init (div_rem_init),
        .den      (div_den),
        .steps    (div_steps),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    kta_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (cor_ctl),
        .a_in    (cor_a),
        .x_in    (xs_reg),
        .y_in    (cor_y),
        .done    (cor_done),
        .x_out   (cor_x_out),
        .y_out   (cor_y_out),
        .z_out   (cor_z_out)
    );

    kta_sqrt #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .val     (sq_val),
        .done    (sq_done),
        .root    (sq_root)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ecc_reg    <= '0;
            period_reg <= '0;
            peri_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                kta_pkg::CFG_ECCENTRICITY:   ecc_reg    <= cfg_data[kta_pkg::ECC_W-1:0];
                kta_pkg::CFG_ORBIT_PERIOD:   period_reg <= cfg_data[PERW-1:0];
                kta_pkg::CFG_PERIAPSIS_TIME: peri_reg   <= $signed(cfg_data[TW-1:0]);
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if ((state_reg == S_OUT) && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        t_reg <= s_query_time;
                        if (period_reg == '0) begin
                            res_ta_reg <= '0;
                            res_st_reg <= kta_pkg::STATUS_PERIOD_ZERO;
                            state_reg  <= S_OUT;
                        end else if (ecc_reg[kta_pkg::ECC_W-1]) begin
                            res_ta_reg <= '0;
                            res_st_reg <= kta_pkg::STATUS_NOT_ELLIPTIC;
                            state_reg  <= S_OUT;
                        end else begin
                            state_reg <= S_MOD_GO;
                        end
                    end
                end
                S_MOD_GO: begin
                    neg_reg   <= dt[TW];
                    state_reg <= S_MOD_WAIT;
                end
                S_MOD_WAIT: begin
                    if (div_done) begin
                        rem_reg   <= rem_fix;
                        state_reg <= S_FRAC_GO;
                    end
                end
                S_FRAC_GO: state_reg <= S_FRAC_WAIT;
                S_FRAC_WAIT: begin
                    if (div_done) begin
                        q_reg     <= div_quot[31:0];
                        state_reg <= S_MMUL;
                    end
                end
                S_MMUL: state_reg <= S_MCAP;
                S_MCAP: begin
                    m_reg     <= AW'(prod >>> 32);
                    e_reg     <= '0;
                    k_reg     <= '0;
                    state_reg <= S_SC_GO;
                end
                S_SC_GO: state_reg <= S_SC_WAIT;
                S_SC_WAIT: begin
                    if (cor_done) begin
                        s_reg     <= cor_y_out;
                        c_reg     <= cor_x_out;
                        state_reg <= S_EMS;
                    end
                end
                S_EMS: state_reg <= S_EMC;
                S_EMC: begin
                    f_reg     <= e_reg - AW'(prod >>> 31) - m_reg;
                    state_reg <= S_DIV_GO;
                end
                S_DIV_GO: state_reg <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (div_done) begin
                        e_reg <= e_clamp;
                        if ((f_reg == '0) || (k_reg >= KW'(NEWTON_STEP_LIMIT))) begin
                            state_reg <= S_HALF_GO;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_SC_GO;
                        end
                    end
                end
                S_HALF_GO: state_reg <= S_HALF_WAIT;
                S_HALF_WAIT: begin
                    if (cor_done) begin
                        s_reg     <= cor_y_out;
                        c_reg     <= cor_x_out;
                        state_reg <= S_SQM_GO;
                    end
                end
                S_SQM_GO: state_reg <= S_SQM_WAIT;
                S_SQM_WAIT: begin
                    if (sq_done) begin
                        sm_reg    <= sq_root;
                        state_reg <= S_SQP_GO;
                    end
                end
                S_SQP_GO: state_reg <= S_SQP_WAIT;
                S_SQP_WAIT: begin
                    if (sq_done) begin
                        sp_reg    <= sq_root;
                        state_reg <= S_XS;
                    end
                end
                S_XS: state_reg <= S_YS;
                S_YS: begin
                    xs_reg    <= AW'(prod >>> F);
                    state_reg <= S_VEC_GO;
                end
                S_VEC_GO: state_reg <= S_VEC_WAIT;
                S_VEC_WAIT: begin
                    if (cor_done) begin
                        res_ta_reg <= 32'(nu_clamp) << (29 - F);
                        res_st_reg <= kta_pkg::STATUS_OK;
                        state_reg  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_ta_reg    <= res_ta_reg;
                        m_st_reg    <= res_st_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_true_anomaly = m_ta_reg;
    assign m_status       = m_st_reg;

endmodule
`default_nettype wire
